// ===== design/amu_pkg.sv =====
// Shared types, mode codes and the opcode decode table for the address mode unit.
package amu_pkg;

	typedef enum logic [3:0] {
		AM_IMP = 4'd0,
		AM_ACC = 4'd1,
		AM_IMM = 4'd2,
		AM_ZPG = 4'd3,
		AM_ZPX = 4'd4,
		AM_ZPY = 4'd5,
		AM_ABS = 4'd6,
		AM_ABX = 4'd7,
		AM_ABY = 4'd8,
		AM_IND = 4'd9,
		AM_INX = 4'd10,
		AM_INY = 4'd11,
		AM_REL = 4'd12
	} mode_t;

	localparam logic CMD_DECODE = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// high nibble: mode, low nibble: base cycles
	localparam logic [7:0] DECODE_ROM [0:255] = '{
		8'h07,8'hA6,8'h00,8'h00,8'h00,8'h33,8'h35,8'h00,
		8'h03,8'h22,8'h12,8'h00,8'h00,8'h64,8'h66,8'h00,
		8'hC2,8'hB5,8'h00,8'h00,8'h00,8'h44,8'h46,8'h00,
		8'h02,8'h84,8'h00,8'h00,8'h00,8'h74,8'h77,8'h00,
		8'h66,8'hA6,8'h00,8'h00,8'h33,8'h33,8'h35,8'h00,
		8'h04,8'h22,8'h12,8'h00,8'h64,8'h64,8'h66,8'h00,
		8'hC2,8'hB5,8'h00,8'h00,8'h00,8'h44,8'h46,8'h00,
		8'h02,8'h84,8'h00,8'h00,8'h00,8'h74,8'h77,8'h00,
		8'h06,8'hA6,8'h00,8'h00,8'h00,8'h33,8'h35,8'h00,
		8'h03,8'h22,8'h12,8'h00,8'h63,8'h64,8'h66,8'h00,
		8'hC2,8'hB5,8'h00,8'h00,8'h00,8'h44,8'h46,8'h00,
		8'h02,8'h84,8'h00,8'h00,8'h00,8'h74,8'h77,8'h00,
		8'h06,8'hA6,8'h00,8'h00,8'h00,8'h33,8'h35,8'h00,
		8'h04,8'h22,8'h12,8'h00,8'h95,8'h64,8'h66,8'h00,
		8'hC2,8'hB5,8'h00,8'h00,8'h00,8'h44,8'h46,8'h00,
		8'h02,8'h84,8'h00,8'h00,8'h00,8'h74,8'h77,8'h00,
		8'h00,8'hA6,8'h00,8'h00,8'h33,8'h33,8'h33,8'h00,
		8'h02,8'h00,8'h02,8'h00,8'h64,8'h64,8'h64,8'h00,
		8'hC2,8'hB6,8'h00,8'h00,8'h44,8'h44,8'h54,8'h00,
		8'h02,8'h85,8'h02,8'h00,8'h00,8'h75,8'h00,8'h00,
		8'h22,8'hA6,8'h22,8'h00,8'h33,8'h33,8'h33,8'h00,
		8'h02,8'h22,8'h02,8'h00,8'h64,8'h64,8'h64,8'h00,
		8'hC2,8'hB5,8'h00,8'h00,8'h44,8'h44,8'h54,8'h00,
		8'h02,8'h84,8'h02,8'h00,8'h74,8'h74,8'h84,8'h00,
		8'h22,8'hA6,8'h00,8'h00,8'h33,8'h33,8'h35,8'h00,
		8'h02,8'h22,8'h02,8'h00,8'h64,8'h64,8'h66,8'h00,
		8'hC2,8'hB5,8'h00,8'h00,8'h00,8'h44,8'h46,8'h00,
		8'h02,8'h84,8'h00,8'h00,8'h00,8'h74,8'h77,8'h00,
		8'h22,8'hA6,8'h00,8'h00,8'h33,8'h33,8'h35,8'h00,
		8'h02,8'h22,8'h02,8'h00,8'h64,8'h64,8'h66,8'h00,
		8'hC2,8'hB5,8'h00,8'h00,8'h00,8'h44,8'h46,8'h00,
		8'h02,8'h84,8'h00,8'h00,8'h00,8'h74,8'h77,8'h00
	};

	typedef struct packed {
		logic        cmd;
		logic [7:0]  opcode;
		logic [15:0] opcode_pc;
		logic [7:0]  operand_low;
		logic [7:0]  operand_high;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic        instr_may_add_cycle;
		logic [7:0]  pointer_byte_low;
		logic [7:0]  pointer_byte_high;
	} amu_req_t;

	typedef struct packed {
		logic [3:0]  access_mode;
		logic [15:0] next_pc;
		logic        need_pointer;
		logic [15:0] pointer_addr_low;
		logic [15:0] pointer_addr_high;
		logic [15:0] effective_address;
		logic        page_crossed;
		logic [3:0]  cycle_count;
		logic        address_ready;
	} amu_res_t;

	typedef struct packed {
		logic       valid;
		mode_t      mode;
		logic [2:0] cycles;
		logic       penalty_ok;
		logic [7:0] y;
	} amu_pend_t;

endpackage

// ===== design/amu_calc.sv =====
// Address computation for one request: table decode, next PC, pointer and effective address.
module amu_calc (
	input  amu_pkg::amu_req_t  req,
	input  amu_pkg::amu_pend_t pend,
	output amu_pkg::amu_res_t  res,
	output amu_pkg::amu_pend_t pend_nxt
);

	logic [7:0]      ent;
	amu_pkg::mode_t  mode;
	logic [3:0]      base_cyc;
	logic [1:0]      op_len;
	logic [15:0]     word;
	logic [15:0]     npc;
	logic [15:0]     idx_sum;
	logic [7:0]      zp_x;
	logic [15:0]     ptr;
	logic [15:0]     ptr_y;
	logic            crossed_d;
	logic            crossed_f;

	assign ent      = amu_pkg::DECODE_ROM[req.opcode];
	assign mode     = amu_pkg::mode_t'(ent[7:4]);
	assign base_cyc = ent[3:0];
	assign word     = {req.operand_high, req.operand_low};
	assign zp_x     = req.operand_low + req.index_x;
	assign npc      = req.opcode_pc + 16'd1 + {14'd0, op_len};
	assign idx_sum  = word + {8'd0, (mode == amu_pkg::AM_ABX) ? req.index_x : req.index_y};
	assign crossed_d = (idx_sum[15:8] != req.operand_high);
	assign ptr      = {req.pointer_byte_high, req.pointer_byte_low};
	assign ptr_y    = ptr + {8'd0, pend.y};
	assign crossed_f = (pend.mode == amu_pkg::AM_INY) && (ptr_y[15:8] != ptr[15:8]);

	always_comb begin
		case (mode)
			amu_pkg::AM_IMP, amu_pkg::AM_ACC: op_len = 2'd0;
			amu_pkg::AM_ABS, amu_pkg::AM_ABX,
			amu_pkg::AM_ABY, amu_pkg::AM_IND: op_len = 2'd2;
			default: op_len = 2'd1;
		endcase
	end

	always_comb begin
		res      = '0;
		pend_nxt = pend;
		if (req.cmd == amu_pkg::CMD_DECODE) begin
			res.access_mode   = mode;
			res.next_pc       = npc;
			res.address_ready = 1'b1;
			case (mode)
				amu_pkg::AM_IMP, amu_pkg::AM_ACC: ;
				amu_pkg::AM_IMM: res.effective_address = req.opcode_pc + 16'd1;
				amu_pkg::AM_ZPG: res.effective_address = {8'd0, req.operand_low};
				amu_pkg::AM_ZPX: res.effective_address = {8'd0, zp_x};
				amu_pkg::AM_ZPY: res.effective_address = {8'd0, req.operand_low + req.index_y};
				amu_pkg::AM_ABS: res.effective_address = word;
				amu_pkg::AM_ABX, amu_pkg::AM_ABY: begin
					res.effective_address = idx_sum;
					res.page_crossed      = crossed_d;
				end
				amu_pkg::AM_REL: begin
					res.effective_address = npc + {{8{req.operand_low[7]}}, req.operand_low};
				end
				amu_pkg::AM_IND: begin
					res.pointer_addr_low  = word;
					// indirect jump never carries into the next page
					res.pointer_addr_high = (req.operand_low == 8'hFF) ?
						{req.operand_high, 8'h00} : word + 16'd1;
				end
				amu_pkg::AM_INX: begin
					res.pointer_addr_low  = {8'd0, zp_x};
					res.pointer_addr_high = {8'd0, zp_x + 8'd1};
				end
				amu_pkg::AM_INY: begin
					res.pointer_addr_low  = {8'd0, req.operand_low};
					res.pointer_addr_high = {8'd0, req.operand_low + 8'd1};
				end
				default: ;
			endcase
			if (mode == amu_pkg::AM_IND || mode == amu_pkg::AM_INX ||
			    mode == amu_pkg::AM_INY) begin
				res.need_pointer    = 1'b1;
				res.address_ready   = 1'b0;
				pend_nxt.valid      = 1'b1;
				pend_nxt.mode       = mode;
				pend_nxt.cycles     = base_cyc[2:0];
				pend_nxt.penalty_ok = req.instr_may_add_cycle;
				pend_nxt.y          = req.index_y;
			end else begin
				res.cycle_count = base_cyc + {3'd0, crossed_d && res.page_crossed &&
					req.instr_may_add_cycle};
			end
		end else if (pend.valid) begin
			res.access_mode       = pend.mode;
			res.effective_address = (pend.mode == amu_pkg::AM_INY) ? ptr_y : ptr;
			res.page_crossed      = crossed_f;
			res.cycle_count       = {1'b0, pend.cycles} + {3'd0, crossed_f && pend.penalty_ok};
			res.address_ready     = 1'b1;
			pend_nxt.valid        = 1'b0;
		end
	end

endmodule

// ===== design/cpu_address_mode_unit.sv =====
// Top level of the 8-bit CPU address mode unit: input stage, pending pointer decode, result register.
// A request is captured in the input register when accepted, and its result is captured in the
// result register as the request leaves the input register; that waits while an offered result
// is not taken. A new request is accepted every cycle while results are taken; throughput is one
// request per clock, limited only by the output side taking results. A decode request (cmd 0)
// returns mode, next PC, cycle count and effective address; for the indirect modes it instead
// returns the two pointer byte addresses and keeps the decode pending until a finish request
// (cmd 1) brings the fetched bytes. A finish request with nothing pending returns an all-zero result.
module cpu_address_mode_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  opcode,
	input  logic [15:0] opcode_pc,
	input  logic [7:0]  operand_low,
	input  logic [7:0]  operand_high,
	input  logic [7:0]  index_x,
	input  logic [7:0]  index_y,
	input  logic        instr_may_add_cycle,
	input  logic [7:0]  pointer_byte_low,
	input  logic [7:0]  pointer_byte_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  access_mode,
	output logic [15:0] next_pc,
	output logic        need_pointer,
	output logic [15:0] pointer_addr_low,
	output logic [15:0] pointer_addr_high,
	output logic [15:0] effective_address,
	output logic        page_crossed,
	output logic [3:0]  cycle_count,
	output logic        address_ready
);

	amu_pkg::amu_req_t  req_s1;
	logic               valid_s1;
	amu_pkg::amu_pend_t pend_q;
	amu_pkg::amu_pend_t pend_nxt;
	amu_pkg::amu_res_t  res_d;
	amu_pkg::amu_res_t  res_q;
	logic               out_valid_q;
	logic               adv_s1;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= '{cmd, opcode, opcode_pc, operand_low, operand_high, index_x, index_y,
				instr_may_add_cycle, pointer_byte_low, pointer_byte_high};
		end
	end

	amu_calc u_calc (
		.req      (req_s1),
		.pend     (pend_q),
		.res      (res_d),
		.pend_nxt (pend_nxt)
	);

	// pending decode follows request order: it changes only as a request leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '{valid: 1'b0, mode: amu_pkg::AM_IMP, cycles: 3'd0,
				penalty_ok: 1'b0, y: 8'd0};
		end else if (adv_s1) begin
			pend_q <= pend_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign access_mode       = res_q.access_mode;
	assign next_pc           = res_q.next_pc;
	assign need_pointer      = res_q.need_pointer;
	assign pointer_addr_low  = res_q.pointer_addr_low;
	assign pointer_addr_high = res_q.pointer_addr_high;
	assign effective_address = res_q.effective_address;
	assign page_crossed      = res_q.page_crossed;
	assign cycle_count       = res_q.cycle_count;
	assign address_ready     = res_q.address_ready;

endmodule

// ===== design/amu_checker.sv =====
// Port-level checks for the address mode unit and the bind that attaches them.
module amu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  access_mode,
	input logic        need_pointer,
	input logic        page_crossed,
	input logic [3:0]  cycle_count,
	input logic        address_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(access_mode) && $stable(cycle_count))
		else $error("result changed while stalled");

	a_ptr_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && need_pointer |-> !address_ready && cycle_count == 4'd0)
		else $error("pointer request marked final");

	a_cross_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && page_crossed |->
		access_mode == amu_pkg::AM_ABX || access_mode == amu_pkg::AM_ABY ||
		access_mode == amu_pkg::AM_INY)
		else $error("page crossing on a non-indexed mode");

	a_empty_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !address_ready && !need_pointer |->
		access_mode == amu_pkg::AM_IMP && cycle_count == 4'd0 && !page_crossed)
		else $error("orphan finish result not cleared");

endmodule

bind cpu_address_mode_unit amu_checker u_amu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.access_mode   (access_mode),
	.need_pointer  (need_pointer),
	.page_crossed  (page_crossed),
	.cycle_count   (cycle_count),
	.address_ready (address_ready)
);
